// ===== hw/rtl/mlp_pkg.sv =====
`default_nettype none

package mlp_pkg;

  localparam int unsigned MAX_L_DEF     = 8;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned IDX_W         = 8;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X_LO   = 8'h78;
  localparam logic [7:0] CH_X_UP   = 8'h58;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_TRAILING      = 4'd1,
    ST_NESTED_LIST   = 4'd2,
    ST_CLOSE_OUTSIDE = 4'd3,
    ST_TUPLE_OUTSIDE = 4'd4,
    ST_NESTED_TUPLE  = 4'd5,
    ST_NO_L          = 4'd6,
    ST_PAREN_OUTSIDE = 4'd7,
    ST_COMMA_OUTSIDE = 4'd8,
    ST_NO_M          = 4'd9,
    ST_RANGE         = 4'd10,
    ST_BAD_CHAR      = 4'd11,
    ST_UNTERMINATED  = 4'd12
  } status_e;

  // one request from the parser to the output side
  typedef struct packed {
    logic             is_final;
    status_e          status;
    logic             list_closed;
    logic             set_vld;
    logic [IDX_W-1:0] set_idx;
  } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mlp_in_if.sv =====
`default_nettype none

interface mlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mlp_out_if.sv =====
`default_nettype none

interface mlp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic        list_closed;
  logic        is_final;
  logic [31:0] mode_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output status, output list_closed, output is_final,
                  output mode_word, output word_index, output last, input ready);
  modport sink (input valid, input status, input list_closed, input is_final,
                input mode_word, input word_index, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mlp_fifo.sv =====
`default_nettype none

module mlp_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  mlp_pkg::entry_t      data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output mlp_pkg::entry_t      data_o
);

  localparam int unsigned Depth = mlp_pkg::FIFO_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  mlp_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mlp_front.sv =====
`default_nettype none

module mlp_front #(
  parameter int unsigned MAX_L = mlp_pkg::MAX_L_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  mlp_in_if.sink           text_i,
  input  wire logic        full_i,
  output logic             push_o,
  output mlp_pkg::entry_t  entry_o
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_START, PH_SIGN, PH_ZERO, PH_HEXPEND, PH_DIGITS
  } phase_e;

  typedef enum logic [1:0] {BASE_DEC, BASE_OCT, BASE_HEX} base_e;

  typedef struct packed {
    logic [15:0]               l;
    logic                      range_err;
    logic                      set_vld;
    logic [mlp_pkg::IDX_W-1:0] idx;
  } fin_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {[8'd9:8'd13], mlp_pkg::CH_SPACE};
  endfunction

  // {valid, value} of a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {["0":"9"]}) begin
      r = {1'b1, 4'(c - "0")};
    end else if (c inside {["a":"f"]}) begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c inside {["A":"F"]}) begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic [15:0] acc(input logic [15:0] v, input base_e b,
                                      input logic [3:0] d);
    logic [20:0] w;
    case (b)
      BASE_HEX: w = {1'b0, v, 4'b0};
      BASE_OCT: w = {2'b0, v, 3'b0};
      default:  w = {2'b0, v, 3'b0} + {4'b0, v, 1'b0};
    endcase
    w = w + 21'(d);
    return (w > 21'h00FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic fin_t finish(input logic is_m, input logic neg,
                                  input logic [15:0] mag, input logic [15:0] lcur);
    fin_t       f;
    logic [8:0] base;
    logic [8:0] idx9;
    f = '0;
    f.l = lcur;
    if (!is_m) begin
      f.l = (neg && mag != '0) ? 16'hFFFF : mag;
    end else if (lcur > 16'(MAX_L) || mag > lcur) begin
      f.range_err = 1'b1;
    end else begin
      base = 9'(lcur[3:0]) * 9'(lcur[3:0]) + 9'(lcur[3:0]);
      idx9 = neg ? base - 9'(mag[3:0]) : base + 9'(mag[3:0]);
      f.set_vld = 1'b1;
      f.idx = idx9[mlp_pkg::IDX_W-1:0];
    end
    return f;
  endfunction

  logic               in_list_q, in_list_d;
  logic               in_tuple_q, in_tuple_d;
  logic               done_q, done_d;
  mlp_pkg::status_e   err_q, err_d;
  phase_e             phase_q, phase_d;
  logic               is_m_q, is_m_d;
  logic               neg_q, neg_d;
  base_e              base_q, base_d;
  logic [15:0]        val_q, val_d;
  logic [15:0]        l_q, l_d;

  fin_t       fin;
  logic       taken;
  logic       set_vld;
  logic [mlp_pkg::IDX_W-1:0] set_idx;
  logic [7:0] c;
  logic [4:0] hd;
  logic       dig_ok;

  assign c      = text_i.text_char;
  assign hd     = hex_digit(c);
  assign fin    = finish(is_m_q, neg_q, val_q, l_q);
  assign dig_ok = hd[4] && ((base_q == BASE_HEX) ||
                            (base_q == BASE_OCT && hd[3:0] < 4'd8) ||
                            (base_q == BASE_DEC && hd[3:0] < 4'd10));

  assign text_i.ready = !full_i;
  assign push_o       = text_i.valid && !full_i;

  always_comb begin
    in_list_d  = in_list_q;
    in_tuple_d = in_tuple_q;
    done_d     = done_q;
    err_d      = err_q;
    phase_d    = phase_q;
    is_m_d     = is_m_q;
    neg_d      = neg_q;
    base_d     = base_q;
    val_d      = val_q;
    l_d        = l_q;
    taken      = 1'b0;
    set_vld    = 1'b0;
    set_idx    = fin.idx;

    if (text_i.end_of_text) begin
      if (err_q == mlp_pkg::ST_OK) begin
        case (phase_q)
          PH_START, PH_SIGN: begin
            err_d = is_m_q ? mlp_pkg::ST_NO_M : mlp_pkg::ST_NO_L;
          end
          PH_ZERO, PH_DIGITS, PH_HEXPEND: begin
            if (fin.range_err) begin
              err_d = mlp_pkg::ST_RANGE;
            end else begin
              set_vld = fin.set_vld;
              if (phase_q == PH_HEXPEND) begin
                err_d = mlp_pkg::ST_BAD_CHAR;
              end
            end
          end
          default: ;
        endcase
        if (err_d == mlp_pkg::ST_OK && !done_q) begin
          err_d = mlp_pkg::ST_UNTERMINATED;
        end
      end
    end else if (err_q == mlp_pkg::ST_OK) begin
      case (phase_q)
        PH_START, PH_SIGN: begin
          taken = 1'b1;
          if (phase_q == PH_START && is_space(c)) begin
            phase_d = PH_START;
          end else if (phase_q == PH_START && (c == mlp_pkg::CH_PLUS ||
                                               c == mlp_pkg::CH_MINUS)) begin
            neg_d   = (c == mlp_pkg::CH_MINUS);
            phase_d = PH_SIGN;
          end else if (c == mlp_pkg::CH_ZERO) begin
            phase_d = PH_ZERO;
          end else if (c inside {["1":"9"]}) begin
            phase_d = PH_DIGITS;
            val_d   = acc(val_q, base_q, hd[3:0]);
          end else begin
            err_d   = is_m_q ? mlp_pkg::ST_NO_M : mlp_pkg::ST_NO_L;
            phase_d = PH_IDLE;
          end
        end
        PH_ZERO: begin
          if (c == mlp_pkg::CH_X_LO || c == mlp_pkg::CH_X_UP) begin
            taken   = 1'b1;
            phase_d = PH_HEXPEND;
          end else if (c inside {["0":"7"]}) begin
            taken   = 1'b1;
            base_d  = BASE_OCT;
            phase_d = PH_DIGITS;
            val_d   = acc(val_q, BASE_OCT, hd[3:0]);
          end
        end
        PH_HEXPEND: begin
          taken = 1'b1;
          if (hd[4]) begin
            base_d  = BASE_HEX;
            phase_d = PH_DIGITS;
            val_d   = acc(val_q, BASE_HEX, hd[3:0]);
          end
        end
        PH_DIGITS: begin
          if (dig_ok) begin
            taken = 1'b1;
            val_d = acc(val_q, base_q, hd[3:0]);
          end
        end
        default: ;
      endcase

      // number ended on this byte
      if (phase_q inside {PH_ZERO, PH_HEXPEND, PH_DIGITS} && phase_d == phase_q &&
          !(phase_q == PH_DIGITS && taken)) begin
        phase_d = PH_IDLE;
        l_d     = fin.l;
        if (fin.range_err) begin
          err_d = mlp_pkg::ST_RANGE;
        end else begin
          set_vld = fin.set_vld;
          if (phase_q == PH_HEXPEND) begin
            err_d = mlp_pkg::ST_BAD_CHAR;
          end
        end
      end

      if (!taken && err_d == mlp_pkg::ST_OK && !is_space(c)) begin
        if (done_q) begin
          err_d = mlp_pkg::ST_TRAILING;
        end else begin
          case (c)
            mlp_pkg::CH_LBRACK: begin
              if (in_list_q) err_d = mlp_pkg::ST_NESTED_LIST;
              else in_list_d = 1'b1;
            end
            mlp_pkg::CH_RBRACK: begin
              if (!in_list_q) begin
                err_d = mlp_pkg::ST_CLOSE_OUTSIDE;
              end else begin
                in_list_d = 1'b0;
                done_d    = 1'b1;
              end
            end
            mlp_pkg::CH_LPAREN: begin
              if (!in_list_q) begin
                err_d = mlp_pkg::ST_TUPLE_OUTSIDE;
              end else if (in_tuple_q) begin
                err_d = mlp_pkg::ST_NESTED_TUPLE;
              end else begin
                in_tuple_d = 1'b1;
                phase_d    = PH_START;
                is_m_d     = 1'b0;
                neg_d      = 1'b0;
                base_d     = BASE_DEC;
                val_d      = '0;
              end
            end
            mlp_pkg::CH_RPAREN: begin
              if (!in_tuple_q) err_d = mlp_pkg::ST_PAREN_OUTSIDE;
              else if (!in_list_q) err_d = mlp_pkg::ST_TUPLE_OUTSIDE;
              else in_tuple_d = 1'b0;
            end
            mlp_pkg::CH_COMMA: begin
              if (!in_list_q) begin
                err_d = mlp_pkg::ST_COMMA_OUTSIDE;
              end else if (in_tuple_q) begin
                phase_d = PH_START;
                is_m_d  = 1'b1;
                neg_d   = 1'b0;
                base_d  = BASE_DEC;
                val_d   = '0;
              end
            end
            default: err_d = mlp_pkg::ST_BAD_CHAR;
          endcase
        end
      end
    end
  end

  always_comb begin
    entry_o.is_final    = text_i.end_of_text;
    entry_o.status      = err_d;
    entry_o.list_closed = text_i.end_of_text ? done_q : done_d;
    entry_o.set_vld     = set_vld && (err_d == mlp_pkg::ST_OK);
    entry_o.set_idx     = set_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_list_q  <= 1'b0;
      in_tuple_q <= 1'b0;
      done_q     <= 1'b0;
      err_q      <= mlp_pkg::ST_OK;
      phase_q    <= PH_IDLE;
      is_m_q     <= 1'b0;
      neg_q      <= 1'b0;
      base_q     <= BASE_DEC;
      val_q      <= '0;
      l_q        <= 16'hFFFF;
    end else if (push_o) begin
      if (text_i.end_of_text) begin
        in_list_q  <= 1'b0;
        in_tuple_q <= 1'b0;
        done_q     <= 1'b0;
        err_q      <= mlp_pkg::ST_OK;
        phase_q    <= PH_IDLE;
        is_m_q     <= 1'b0;
        neg_q      <= 1'b0;
        base_q     <= BASE_DEC;
        val_q      <= '0;
        l_q        <= 16'hFFFF;
      end else begin
        in_list_q  <= in_list_d;
        in_tuple_q <= in_tuple_d;
        done_q     <= done_d;
        err_q      <= err_d;
        phase_q    <= phase_d;
        is_m_q     <= is_m_d;
        neg_q      <= neg_d;
        base_q     <= base_d;
        val_q      <= val_d;
        l_q        <= l_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mlp_back.sv =====
`default_nettype none

module mlp_back #(
  parameter int unsigned MAX_L     = mlp_pkg::MAX_L_DEF,
  parameter int unsigned WORD_BITS = mlp_pkg::WORD_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        empty_i,
  input  mlp_pkg::entry_t  head_i,
  output logic             pop_o,
  mlp_out_if.source        result_o
);

  localparam int unsigned ModeCount = (MAX_L + 1) * (MAX_L + 1);
  localparam int unsigned RawWords  = (ModeCount + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned OutWords  = (RawWords > 8) ? 8 : RawWords;
  localparam int unsigned BmpBits   = OutWords * WORD_BITS;
  localparam int unsigned CopyBits  = (WORD_BITS > 32) ? 32 : WORD_BITS;

  typedef enum logic {S_PASS, S_WORDS} state_e;

  state_e               state_q;
  logic [2:0]           k_q;
  logic [BmpBits-1:0]   bmp_q;
  logic [BmpBits-1:0]   set_mask;
  logic [WORD_BITS-1:0] wsel;
  logic                 load;
  logic                 last_word;
  logic                 emit;

  logic                 ovld_q;
  mlp_pkg::status_e     status_q;
  logic                 closed_q;
  logic                 final_q;
  logic [31:0]          word_q;
  logic [2:0]           idx_q;
  logic                 last_q;

  always_comb begin
    for (int b = 0; b < BmpBits; b++) begin
      set_mask[b] = head_i.set_vld && (int'(head_i.set_idx) == b);
    end
  end

  assign wsel      = bmp_q[int'(k_q) * WORD_BITS +: WORD_BITS];
  assign load      = !ovld_q || result_o.ready;
  assign last_word = (k_q == 3'(OutWords - 1));
  assign pop_o     = (state_q == S_PASS) && !empty_i && load;
  // a new result enters the output register this cycle
  assign emit      = (state_q == S_PASS) ?
                     (pop_o && !(head_i.is_final && head_i.status == mlp_pkg::ST_OK)) :
                     load;

  assign result_o.valid       = ovld_q;
  assign result_o.status      = status_q;
  assign result_o.list_closed = closed_q;
  assign result_o.is_final    = final_q;
  assign result_o.mode_word   = word_q;
  assign result_o.word_index  = idx_q;
  assign result_o.last        = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_PASS;
      k_q      <= '0;
      bmp_q    <= '0;
      ovld_q   <= 1'b0;
      status_q <= mlp_pkg::ST_OK;
      closed_q <= 1'b0;
      final_q  <= 1'b0;
      word_q   <= '0;
      idx_q    <= '0;
      last_q   <= 1'b0;
    end else begin
      if (emit) begin
        ovld_q <= 1'b1;
      end else if (result_o.ready) begin
        ovld_q <= 1'b0;
      end
      case (state_q)
        S_PASS: begin
          if (pop_o) begin
            if (head_i.is_final && head_i.status == mlp_pkg::ST_OK) begin
              // bitmap goes out word by word from the S_WORDS state
              bmp_q   <= bmp_q | set_mask;
              k_q     <= '0;
              state_q <= S_WORDS;
            end else begin
              bmp_q    <= head_i.is_final ? '0 : (bmp_q | set_mask);
              status_q <= head_i.status;
              closed_q <= head_i.list_closed;
              final_q  <= head_i.is_final;
              word_q   <= '0;
              idx_q    <= '0;
              last_q   <= 1'b1;
            end
          end
        end
        S_WORDS: begin
          if (load) begin
            status_q <= mlp_pkg::ST_OK;
            closed_q <= 1'b1;
            final_q  <= 1'b1;
            word_q   <= 32'(wsel[CopyBits-1:0]);
            idx_q    <= k_q;
            last_q   <= last_word;
            if (last_word) begin
              bmp_q   <= '0;
              state_q <= S_PASS;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        default: state_q <= S_PASS;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mode_list_text_parser.sv =====
// Channel   Dir  Payload                                          Per request
// text_i    in   text_char, end_of_text                           one byte or end of text
// result_o  out  status, list_closed, is_final, mode_word,        one result per byte;
//                word_index, last                                 1..8 at end of text
//
// The parser takes one byte per cycle while the queue is not full; each byte
// updates the flags and the number being read; its entry sets at most one bitmap bit.
// A 4-entry queue sits between the parser and the output register, so the input
// keeps flowing while a result waits on result_o.ready, until the queue is full.
// End of text without error sends the bitmap out word by word at the output side;
// the parser is back in its reset state on the next byte.
// Reset is asynchronous, active low; it clears flags, the queue and the bitmap.
`default_nettype none

module mode_list_text_parser #(
  parameter int unsigned MAX_L     = mlp_pkg::MAX_L_DEF,
  parameter int unsigned WORD_BITS = mlp_pkg::WORD_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mlp_in_if.sink      text_i,
  mlp_out_if.source   result_o
);

  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  mlp_pkg::entry_t entry_in;
  mlp_pkg::entry_t entry_out;

  mlp_front #(
    .MAX_L (MAX_L)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry_in)
  );

  mlp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (entry_out)
  );

  mlp_back #(
    .MAX_L     (MAX_L),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .head_i   (entry_out),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

// ===== verif/mode_list_text_parser_test.sv =====
`timescale 1ns / 1ps

module mode_list_text_parser_test;

  localparam int unsigned MAX_L      = mlp_pkg::MAX_L_DEF;
  localparam int unsigned MODE_TOTAL = (MAX_L + 1) * (MAX_L + 1);
  localparam int unsigned RAW_WORDS  = (MODE_TOTAL + 31) / 32;
  localparam int unsigned MAP_WORDS  = (RAW_WORDS > 8) ? 8 : RAW_WORDS;
  localparam int unsigned SAT_VALUE  = 32'hFFFF;

  typedef enum logic [2:0] {
    NUM_IDLE, NUM_START, NUM_SIGN, NUM_ZERO, NUM_HEX_PEND, NUM_DIGITS
  } num_phase_e;

  typedef enum logic [1:0] {RADIX_DEC, RADIX_OCT, RADIX_HEX} radix_e;

  typedef struct {
    mlp_pkg::status_e status;
    logic             list_closed;
    logic             is_final;
    logic [31:0]      mode_word;
    logic [2:0]       word_index;
    logic             last;
  } mode_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mlp_in_if  text_if ();
  mlp_out_if result_if ();

  mode_list_text_parser i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_if),
    .result_o (result_if)
  );

  always #2 clk_i = ~clk_i;

  // parser shadow state
  logic [255:0]     map_bits;
  bit               list_open, tuple_open, list_done;
  mlp_pkg::status_e err_code;
  num_phase_e       num_phase;
  bit               num_is_m, num_neg;
  radix_e           num_radix;
  int unsigned      num_val, l_val;

  mode_result_t pending_results[$];
  logic [7:0]   text_buf[$];
  int           mismatch_count = 0;
  int           src_idle_pct, snk_stall_pct;

  function automatic void clear_parser();
    map_bits   = '0;
    list_open  = 1'b0;
    tuple_open = 1'b0;
    list_done  = 1'b0;
    err_code   = mlp_pkg::ST_OK;
    num_phase  = NUM_IDLE;
    num_is_m   = 1'b0;
    num_neg    = 1'b0;
    num_radix  = RADIX_DEC;
    num_val    = 0;
    l_val      = SAT_VALUE;
  endfunction

  function automatic void flag_error(mlp_pkg::status_e code);
    if (err_code == mlp_pkg::ST_OK) err_code = code;
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return c == mlp_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic int digit_value(logic [7:0] c, radix_e r);
    int d;
    d = -1;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "f") d = c - "a" + 10;
    else if (c >= "A" && c <= "F") d = c - "A" + 10;
    if (r == RADIX_HEX) return d;
    if (r == RADIX_OCT) return (d >= 0 && d < 8) ? d : -1;
    return (d >= 0 && d < 10) ? d : -1;
  endfunction

  function automatic void accumulate(int unsigned d);
    int unsigned mult, v;
    mult = (num_radix == RADIX_HEX) ? 16 : (num_radix == RADIX_OCT) ? 8 : 10;
    v = num_val * mult + d;
    num_val = (v > SAT_VALUE) ? SAT_VALUE : v;
  endfunction

  function automatic void begin_number(bit is_m);
    num_phase = NUM_START;
    num_is_m  = is_m;
    num_neg   = 1'b0;
    num_radix = RADIX_DEC;
    num_val   = 0;
  endfunction

  function automatic void close_number();
    int unsigned mag, idx;
    mag = num_val;
    num_phase = NUM_IDLE;
    if (!num_is_m) begin
      // negative l other than -0 is forced out of range
      l_val = (num_neg && mag != 0) ? SAT_VALUE : mag;
      return;
    end
    if (l_val > MAX_L || mag > l_val) begin
      flag_error(mlp_pkg::ST_RANGE);
      return;
    end
    idx = l_val * l_val + l_val;
    idx = num_neg ? idx - mag : idx + mag;
    map_bits[idx[7:0]] = 1'b1;
  endfunction

  // returns 1 when the byte was consumed by the number
  function automatic bit take_number_char(logic [7:0] c);
    int d;
    case (num_phase)
      NUM_START, NUM_SIGN: begin
        if (num_phase == NUM_START) begin
          if (is_ws(c)) return 1'b1;
          if (c == mlp_pkg::CH_PLUS || c == mlp_pkg::CH_MINUS) begin
            num_neg   = (c == mlp_pkg::CH_MINUS);
            num_phase = NUM_SIGN;
            return 1'b1;
          end
        end
        if (c == mlp_pkg::CH_ZERO) begin
          num_phase = NUM_ZERO;
        end else if (c >= "1" && c <= "9") begin
          num_phase = NUM_DIGITS;
          accumulate(c - mlp_pkg::CH_ZERO);
        end else begin
          flag_error(num_is_m ? mlp_pkg::ST_NO_M : mlp_pkg::ST_NO_L);
          num_phase = NUM_IDLE;
        end
        return 1'b1;
      end
      NUM_ZERO: begin
        if (c == mlp_pkg::CH_X_LO || c == mlp_pkg::CH_X_UP) begin
          num_phase = NUM_HEX_PEND;
          return 1'b1;
        end
        if (c >= "0" && c <= "7") begin
          num_radix = RADIX_OCT;
          num_phase = NUM_DIGITS;
          accumulate(c - mlp_pkg::CH_ZERO);
          return 1'b1;
        end
        close_number();
        return 1'b0;
      end
      NUM_HEX_PEND: begin
        d = digit_value(c, RADIX_HEX);
        if (d >= 0) begin
          num_radix = RADIX_HEX;
          num_phase = NUM_DIGITS;
          accumulate(d);
          return 1'b1;
        end
        close_number();
        flag_error(mlp_pkg::ST_BAD_CHAR);
        return 1'b1;
      end
      NUM_DIGITS: begin
        d = digit_value(c, num_radix);
        if (d >= 0) begin
          accumulate(d);
          return 1'b1;
        end
        close_number();
        return 1'b0;
      end
      default: begin
        num_phase = NUM_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void parse_char(logic [7:0] c);
    if (err_code != mlp_pkg::ST_OK) return;
    if (num_phase != NUM_IDLE) begin
      if (take_number_char(c)) return;
    end
    if (err_code != mlp_pkg::ST_OK || is_ws(c)) return;
    if (list_done) begin
      flag_error(mlp_pkg::ST_TRAILING);
      return;
    end
    case (c)
      mlp_pkg::CH_LBRACK: begin
        if (list_open) flag_error(mlp_pkg::ST_NESTED_LIST);
        else list_open = 1'b1;
      end
      mlp_pkg::CH_RBRACK: begin
        if (!list_open) flag_error(mlp_pkg::ST_CLOSE_OUTSIDE);
        else begin
          list_open = 1'b0;
          list_done = 1'b1;
        end
      end
      mlp_pkg::CH_LPAREN: begin
        if (!list_open) flag_error(mlp_pkg::ST_TUPLE_OUTSIDE);
        else if (tuple_open) flag_error(mlp_pkg::ST_NESTED_TUPLE);
        else begin
          tuple_open = 1'b1;
          begin_number(1'b0);
        end
      end
      mlp_pkg::CH_RPAREN: begin
        if (!tuple_open) flag_error(mlp_pkg::ST_PAREN_OUTSIDE);
        else if (!list_open) flag_error(mlp_pkg::ST_TUPLE_OUTSIDE);
        else tuple_open = 1'b0;
      end
      mlp_pkg::CH_COMMA: begin
        if (!list_open) flag_error(mlp_pkg::ST_COMMA_OUTSIDE);
        else if (tuple_open) begin_number(1'b1);
      end
      default: flag_error(mlp_pkg::ST_BAD_CHAR);
    endcase
  endfunction

  function automatic void predict_step(logic [7:0] c, logic eot);
    mode_result_t r;
    r.mode_word  = '0;
    r.word_index = '0;
    r.last       = 1'b1;
    if (!eot) begin
      parse_char(c);
      r.status      = err_code;
      r.list_closed = list_done;
      r.is_final    = 1'b0;
      pending_results.push_back(r);
      return;
    end
    if (err_code == mlp_pkg::ST_OK) begin
      case (num_phase)
        NUM_START, NUM_SIGN: flag_error(num_is_m ? mlp_pkg::ST_NO_M : mlp_pkg::ST_NO_L);
        NUM_ZERO, NUM_DIGITS: close_number();
        NUM_HEX_PEND: begin
          close_number();
          flag_error(mlp_pkg::ST_BAD_CHAR);
        end
        default: ;
      endcase
      num_phase = NUM_IDLE;
    end
    if (err_code == mlp_pkg::ST_OK && !list_done) flag_error(mlp_pkg::ST_UNTERMINATED);
    r.is_final    = 1'b1;
    r.list_closed = list_done;
    r.status      = err_code;
    if (err_code != mlp_pkg::ST_OK) begin
      pending_results.push_back(r);
    end else begin
      for (int k = 0; k < MAP_WORDS; k++) begin
        r.mode_word  = map_bits[k*32 +: 32];
        r.word_index = 3'(k);
        r.last       = (k == MAP_WORDS - 1);
        pending_results.push_back(r);
      end
    end
    clear_parser();
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    mode_result_t want;
    if (rst_ni === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with none pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, result_if.status);
        check_field("list_closed", want.list_closed, result_if.list_closed);
        check_field("is_final", want.is_final, result_if.is_final);
        check_field("mode_word", want.mode_word, result_if.mode_word);
        check_field("word_index", want.word_index, result_if.word_index);
        check_field("last", want.last, result_if.last);
      end
    end
  end

  always @(negedge clk_i) result_if.ready <= ($urandom_range(99) >= snk_stall_pct);

  task automatic send_request(input logic [7:0] ch, input logic eot);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(99) < src_idle_pct) text_if.valid <= 1'b0;
      else break;
    end
    text_if.valid       <= 1'b1;
    text_if.text_char   <= ch;
    text_if.end_of_text <= eot;
    @(posedge clk_i);
    while (text_if.ready !== 1'b1) @(posedge clk_i);
    predict_step(ch, eot);
  endtask

  // sends text_buf, then end of text with a random ignored byte
  task automatic send_text();
    foreach (text_buf[i]) send_request(text_buf[i], 1'b0);
    send_request(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    text_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic void maybe_space();
    logic [7:0] b;
    if ($urandom_range(3) == 0) begin
      b = 8'($urandom_range(8, 13));
      text_buf.push_back(b == 8'd8 ? mlp_pkg::CH_SPACE : b);
    end
  endfunction

  function automatic void push_number(int unsigned mag, bit neg);
    string digits;
    maybe_space();
    if (neg) text_buf.push_back(mlp_pkg::CH_MINUS);
    else if ($urandom_range(5) == 0) text_buf.push_back(mlp_pkg::CH_PLUS);
    case ($urandom_range(9))
      0: digits = $sformatf("0%0o", mag);
      1: digits = $sformatf("00%0o", mag);
      2, 3: begin
        digits = $sformatf("%0h", mag);
        if ($urandom_range(1)) digits = digits.toupper();
        if ($urandom_range(1)) digits = {"0x", digits};
        else digits = {"0X", digits};
      end
      default: digits = $sformatf("%0d", mag);
    endcase
    push_str(digits);
    maybe_space();
  endfunction

  function automatic void build_text();
    int unsigned l_mag, m_mag, l_eff, pick, idx;
    bit          l_neg;
    logic [7:0]  glyphs[10];
    glyphs = '{mlp_pkg::CH_LBRACK, mlp_pkg::CH_RBRACK, mlp_pkg::CH_LPAREN,
               mlp_pkg::CH_RPAREN, mlp_pkg::CH_COMMA, mlp_pkg::CH_PLUS,
               mlp_pkg::CH_MINUS, mlp_pkg::CH_X_LO, "8", "a"};
    text_buf.delete();
    maybe_space();
    text_buf.push_back(mlp_pkg::CH_LBRACK);
    repeat ($urandom_range(0, 5)) begin
      maybe_space();
      text_buf.push_back(mlp_pkg::CH_LPAREN);
      pick  = $urandom_range(19);
      l_neg = 1'b0;
      if (pick < 15) l_mag = $urandom_range(MAX_L);
      else if (pick < 17) l_mag = $urandom_range(MAX_L + 1, 40);
      else if (pick < 19) l_mag = $urandom_range(65000, 1000000);
      else begin
        l_neg = 1'b1;
        l_mag = $urandom_range(3);
      end
      push_number(l_mag, l_neg);
      l_eff = (l_neg && l_mag != 0) ? SAT_VALUE : l_mag;
      pick  = $urandom_range(19);
      repeat ((pick < 2) ? 0 : (pick < 17) ? 1 : 2) begin
        text_buf.push_back(mlp_pkg::CH_COMMA);
        if (l_eff <= MAX_L && $urandom_range(9) < 8) m_mag = $urandom_range(l_eff);
        else m_mag = $urandom_range(20);
        push_number(m_mag, 1'($urandom_range(1)));
      end
      text_buf.push_back(mlp_pkg::CH_RPAREN);
      maybe_space();
      text_buf.push_back(mlp_pkg::CH_COMMA);
    end
    // a comma before the closing bracket is legal; drop it half the time
    if ($urandom_range(1) && text_buf[$] == mlp_pkg::CH_COMMA) void'(text_buf.pop_back());
    text_buf.push_back(mlp_pkg::CH_RBRACK);
    maybe_space();

    if ($urandom_range(9) < 3) begin
      idx = $urandom_range(text_buf.size() - 1);
      case ($urandom_range(5))
        0: text_buf[idx] = 8'($urandom_range(255));
        1: text_buf.insert(idx, glyphs[$urandom_range(9)]);
        2: while (text_buf.size() > idx) void'(text_buf.pop_back());
        3: text_buf.push_back(8'($urandom_range(33, 126)));
        4: begin
          if ($urandom_range(1)) begin
            text_buf.insert(idx, mlp_pkg::CH_X_LO);
            text_buf.insert(idx, mlp_pkg::CH_ZERO);
          end else begin
            text_buf.insert(idx, "9");
            text_buf.insert(idx, mlp_pkg::CH_ZERO);
          end
        end
        default: begin
          text_buf.delete();
          repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom_range(255)));
        end
      endcase
    end
  endfunction

  task automatic run_directed_cases();
    string cases[$];
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    cases = '{"[(2,2),(3,-1)]", "[(8,-8),(-0,0),(1,+1,-1)]", " [\t(0x8 ,-010),(07,0X7 )] ",
              "[(08,0)]", "[(1,0x)]", "[(-,1)]", "[(1,-", "[(99999,0)]", "[(-3,0)]",
              "[(2,3)]", "]", "[[", "(", "[((", "[)", ",", "[]x", "[(1,1)", "[(0x", "a", ""};
    foreach (cases[i]) begin
      text_buf.delete();
      push_str(cases[i]);
      send_text();
    end
    // zero byte and top byte are invalid characters
    text_buf.delete();
    text_buf.push_back(8'h00);
    send_text();
    text_buf.delete();
    text_buf.push_back(mlp_pkg::CH_LBRACK);
    text_buf.push_back(8'hFF);
    send_text();
  endtask

  task automatic run_random_texts(input int src_pct, input int snk_pct, input int n_items);
    int sent;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      build_text();
      sent += text_buf.size() + 1;
      send_text();
    end
    // hold off new requests until the parser has answered everything
    wait_for_results();
  endtask

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni                = 1'b0;
    text_if.valid         = 1'b0;
    text_if.text_char     = '0;
    text_if.end_of_text   = 1'b0;
    result_if.ready       = 1'b0;
    src_idle_pct          = 0;
    snk_stall_pct         = 0;
    clear_parser();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed_cases();
    wait_for_results();
    run_random_texts(0, 0, 60);
    run_random_texts(84, 0, 60);
    run_random_texts(0, 84, 60);
    run_random_texts(21, 21, 60);

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
